@@ rtl/tnss_pkg.sv @@
// Package for the top-N-by-size selector: record and beat types,
// controller command and status groups. No dependencies.
package tnss_pkg;

    localparam int DefHeapDepth = 16;
    localparam int LimitWidth   = 5;
    localparam logic [LimitWidth-1:0] LimitReset = 5'd10;

    localparam logic OpOffer  = 1'b0;
    localparam logic OpFinish = 1'b1;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] count;
        logic [63:0] total;
    } rec_t;

    typedef struct packed {
        logic        op;
        logic [63:0] entry_key;
        logic [31:0] entry_count;
        logic [63:0] entry_total_size;
    } entry_t;

    typedef struct packed {
        logic [63:0] out_key;
        logic [31:0] out_count;
        logic [63:0] out_total_size;
        logic        out_last;
    } result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;           // latch offered record
        logic up_init;        // hole at end of heap, grow fill
        logic rd_parent;
        logic wr_parent_move; // move parent down into hole
        logic wr_rec_pos;     // drop held record into hole
        logic rd_root;
        logic dn_init;        // hole at root over full heap
        logic rd_children;
        logic wr_child_move;  // move smaller child up into hole
        logic sort_init;
        logic rd_swap;
        logic swap;           // root to end, last becomes held record
        logic em_init;
        logic rd_emit;
        logic emit;
        logic clear_fill;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_finish;
        logic cap_zero;
        logic fill_zero;
        logic fill_lt_cap;
        logic pos_zero;
        logic up_move;
        logic root_beat;
        logic dn_end;
        logic dn_stay;
        logic sort_end;
        logic emit_last;
    } stat_t;

endpackage

@@ rtl/tnss_ram.sv @@
// Generic simple RAM: one write port, two read ports, registered reads.
// No package dependency.
module tnss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [AW-1:0]        raddr_a,
    output logic [WIDTH-1:0]     rdata_a,
    input  logic [AW-1:0]        raddr_b,
    output logic [WIDTH-1:0]     rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ rtl/tnss_dp.sv @@
// Selector datapath: heap RAM, held record, hole position, counters, compares.
// Depends on tnss_pkg and tnss_ram.
module tnss_dp #(
    parameter int HEAP_DEPTH = tnss_pkg::DefHeapDepth
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tnss_pkg::entry_t                  entry,
    input  logic                              cfg_we,
    input  logic [tnss_pkg::LimitWidth-1:0]   cfg_data,
    input  tnss_pkg::cmd_t                    cmd,
    output tnss_pkg::stat_t                   stat,
    output tnss_pkg::result_t                 result
);
    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int FW = $clog2(HEAP_DEPTH + 1);
    localparam int CW = (FW > tnss_pkg::LimitWidth) ? FW : tnss_pkg::LimitWidth;

    logic [tnss_pkg::LimitWidth-1:0] limit_reg;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] pos_reg, pos_next;
    logic [FW-1:0] len_reg, len_next;
    logic [FW-1:0] cnt_reg, cnt_next;  // sort length, then emit index
    tnss_pkg::rec_t rec_reg, rec_next;

    logic [CW-1:0] limit_ext, cap;
    logic [FW-1:0] parent, cnt_m1;
    logic [FW:0]   lc, rc, cnt_p1;
    logic          sel_l, sel_r;
    logic [63:0]   min_total;

    logic           we;
    logic [AW-1:0]  waddr, raddr_a, raddr_b;
    tnss_pkg::rec_t wdata, rdata_a, rdata_b;

    tnss_ram #(.WIDTH($bits(tnss_pkg::rec_t)), .DEPTH(HEAP_DEPTH)) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    // Capacity saturates at the heap depth
    assign limit_ext = CW'(limit_reg);
    assign cap       = (limit_ext > CW'(HEAP_DEPTH)) ? CW'(HEAP_DEPTH) : limit_ext;

    // Heap neighbors of the hole
    assign parent = FW'((pos_reg - 1'b1) >> 1);
    assign lc     = {pos_reg, 1'b1};
    assign rc     = (FW + 1)'({pos_reg, 1'b0}) + (FW + 1)'(2);
    assign cnt_m1 = cnt_reg - 1'b1;
    assign cnt_p1 = (FW + 1)'(cnt_reg) + 1'b1;

    // Pick the smaller child, left on ties, swap only on strict less-than
    assign sel_l     = (lc < (FW + 1)'(len_reg)) && (rdata_a.total < rec_reg.total);
    assign min_total = sel_l ? rdata_a.total : rec_reg.total;
    assign sel_r     = (rc < (FW + 1)'(len_reg)) && (rdata_b.total < min_total);

    // Status to the controller
    always_comb
    begin
        stat.op_finish   = (entry.op == tnss_pkg::OpFinish);
        stat.cap_zero    = (cap == '0);
        stat.fill_zero   = (fill_reg == '0);
        stat.fill_lt_cap = (CW'(fill_reg) < cap);
        stat.pos_zero    = (pos_reg == '0);
        stat.up_move     = (rdata_a.total > rec_reg.total);
        stat.root_beat   = (rec_reg.total > rdata_a.total);
        stat.dn_end      = (lc >= (FW + 1)'(len_reg));
        stat.dn_stay     = !sel_l && !sel_r;
        stat.sort_end    = (cnt_reg <= FW'(1));
        stat.emit_last   = (cnt_p1 == (FW + 1)'(fill_reg));
    end

    // RAM ports
    always_comb
    begin
        we      = 1'b0;
        waddr   = pos_reg[AW-1:0];
        wdata   = rec_reg;
        raddr_a = '0;
        raddr_b = cnt_m1[AW-1:0];
        if (cmd.rd_parent)
        begin
            raddr_a = parent[AW-1:0];
        end
        else if (cmd.rd_children)
        begin
            raddr_a = lc[AW-1:0];
            raddr_b = rc[AW-1:0];
        end
        else if (cmd.rd_emit)
        begin
            raddr_a = cnt_reg[AW-1:0];
        end
        else if (cmd.rd_root)
        begin
            raddr_a = '0;
        end
        else if (cmd.rd_swap)
        begin
            raddr_a = '0;
            raddr_b = cnt_m1[AW-1:0];
        end
        if (cmd.wr_rec_pos)
        begin
            we = 1'b1;
        end
        else if (cmd.wr_parent_move)
        begin
            we    = 1'b1;
            wdata = rdata_a;
        end
        else if (cmd.wr_child_move)
        begin
            we    = 1'b1;
            wdata = sel_r ? rdata_b : rdata_a;
        end
        else if (cmd.swap)
        begin
            we    = 1'b1;
            waddr = cnt_m1[AW-1:0];
            wdata = rdata_a;
        end
    end

    // Next values of the held record, hole and counters
    always_comb
    begin
        rec_next  = rec_reg;
        pos_next  = pos_reg;
        len_next  = len_reg;
        cnt_next  = cnt_reg;
        fill_next = fill_reg;
        if (cmd.take)
        begin
            rec_next.key   = entry.entry_key;
            rec_next.count = entry.entry_count;
            rec_next.total = entry.entry_total_size;
        end
        if (cmd.up_init)
        begin
            pos_next  = fill_reg;
            fill_next = fill_reg + 1'b1;
        end
        if (cmd.wr_parent_move)
        begin
            pos_next = parent;
        end
        if (cmd.dn_init)
        begin
            pos_next = '0;
            len_next = fill_reg;
        end
        if (cmd.wr_child_move)
        begin
            pos_next = sel_r ? rc[FW-1:0] : lc[FW-1:0];
        end
        if (cmd.sort_init)
        begin
            cnt_next = fill_reg;
        end
        if (cmd.swap)
        begin
            rec_next = rdata_b;
            pos_next = '0;
            len_next = cnt_m1;
            cnt_next = cnt_m1;
        end
        if (cmd.em_init)
        begin
            cnt_next = '0;
        end
        if (cmd.emit)
        begin
            cnt_next = cnt_p1[FW-1:0];
        end
        if (cmd.clear_fill)
        begin
            fill_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= tnss_pkg::LimitReset;
            fill_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            fill_reg <= fill_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        pos_reg <= pos_next;
        len_reg <= len_next;
        cnt_reg <= cnt_next;
    end

    // Emitted beat comes straight from the RAM read register
    assign result.out_key        = rdata_a.key;
    assign result.out_count      = rdata_a.count;
    assign result.out_total_size = rdata_a.total;
    assign result.out_last       = stat.emit_last;

endmodule

@@ rtl/tnss_ctrl.sv @@
// Selector controller: sequences sift-up, replace-root sift-down, heapsort, emit.
// Depends on tnss_pkg.
module tnss_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  tnss_pkg::stat_t stat,
    output tnss_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            strobe
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP_RD    = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_ROOT_CMP = 4'd3;
    localparam logic [3:0] S_DN_RD    = 4'd4;
    localparam logic [3:0] S_DN_CMP   = 4'd5;
    localparam logic [3:0] S_SORT_RD  = 4'd6;
    localparam logic [3:0] S_SORT_SWP = 4'd7;
    localparam logic [3:0] S_EM_RD    = 4'd8;
    localparam logic [3:0] S_EM_OUT   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       sorting_reg, sorting_next;
    logic [3:0] dn_done;

    assign busy    = (state_reg != S_IDLE);
    assign strobe  = (state_reg == S_EM_OUT);
    assign dn_done = sorting_reg ? S_SORT_RD : S_IDLE;

    // Next state and commands
    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        sorting_next = sorting_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (stat.op_finish)
                    begin
                        if (stat.cap_zero || stat.fill_zero)
                        begin
                            cmd.clear_fill = 1'b1;
                        end
                        else
                        begin
                            cmd.sort_init = 1'b1;
                            sorting_next  = 1'b1;
                            state_next    = S_SORT_RD;
                        end
                    end
                    else if (!stat.cap_zero)
                    begin
                        if (stat.fill_lt_cap)
                        begin
                            cmd.take    = 1'b1;
                            cmd.up_init = 1'b1;
                            state_next  = S_UP_RD;
                        end
                        else if (!stat.fill_zero)
                        begin
                            cmd.take    = 1'b1;
                            cmd.rd_root = 1'b1;
                            state_next  = S_ROOT_CMP;
                        end
                    end
                end
            end
            S_UP_RD:
            begin
                if (stat.pos_zero)
                begin
                    cmd.wr_rec_pos = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.rd_parent = 1'b1;
                    state_next    = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_move)
                begin
                    cmd.wr_parent_move = 1'b1;
                    state_next         = S_UP_RD;
                end
                else
                begin
                    cmd.wr_rec_pos = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_ROOT_CMP:
            begin
                if (stat.root_beat)
                begin
                    cmd.dn_init = 1'b1;
                    state_next  = S_DN_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DN_RD:
            begin
                if (stat.dn_end)
                begin
                    cmd.wr_rec_pos = 1'b1;
                    state_next     = dn_done;
                end
                else
                begin
                    cmd.rd_children = 1'b1;
                    state_next      = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (stat.dn_stay)
                begin
                    cmd.wr_rec_pos = 1'b1;
                    state_next     = dn_done;
                end
                else
                begin
                    cmd.wr_child_move = 1'b1;
                    state_next        = S_DN_RD;
                end
            end
            S_SORT_RD:
            begin
                if (stat.sort_end)
                begin
                    cmd.em_init  = 1'b1;
                    sorting_next = 1'b0;
                    state_next   = S_EM_RD;
                end
                else
                begin
                    cmd.rd_swap = 1'b1;
                    state_next  = S_SORT_SWP;
                end
            end
            S_SORT_SWP:
            begin
                cmd.swap   = 1'b1;
                state_next = S_DN_RD;
            end
            S_EM_RD:
            begin
                cmd.rd_emit = 1'b1;
                state_next  = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                cmd.emit = 1'b1;
                if (stat.emit_last)
                begin
                    cmd.clear_fill = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_EM_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sorting_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sorting_reg <= sorting_next;
        end
    end

endmodule

@@ rtl/top_n_by_size_selector_top.sv @@
// Top level of the top-N-by-size selector: controller plus heap datapath.
// Depends on tnss_pkg, tnss_ctrl, tnss_dp (and tnss_ram below it).
//
//  channel   handshake                 payload
//  entry     start, busy               entry  (tnss_pkg::entry_t)
//  result    result_strobe             result (tnss_pkg::result_t)
//  config    cfg_valid, cfg_ready      cfg_data (top_limit)
//
// An entry is taken when start is high and busy low. An offer then holds busy
// while it walks the heap (not at all under a zero limit): each heap level takes
// a RAM read state and a compare/write state on the single shared heap RAM. A
// finish sorts in place, then emits beats in turn, reading each from the RAM
// before showing it; a finish with nothing kept does not raise busy.
// Reset empties the heap and sets top_limit to 10. Result beats last one cycle
// and cannot be stalled; config writes are always ready.
module top_n_by_size_selector_top #(
    parameter int HEAP_DEPTH = tnss_pkg::DefHeapDepth
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  tnss_pkg::entry_t                entry,
    output logic                            result_strobe,
    output tnss_pkg::result_t               result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tnss_pkg::LimitWidth-1:0] cfg_data
);
    tnss_pkg::cmd_t  cmd;
    tnss_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    tnss_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (result_strobe)
    );

    tnss_dp #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .entry    (entry),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result)
    );

endmodule
